[hdl/nrop_pkg.sv]
// Shared types, codes and constants for the rudder-order sentence parser.
package nrop_pkg;

    localparam int SOURCE_CHARS = 8;
    localparam logic [16:0] ANGLE_MAX = 17'd99999;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_V     = 8'h56;

    localparam logic [7:0] HDR_TAG [3] = '{8'h52, 8'h4F, 8'h52};

    typedef enum logic [2:0] {
        RES_OK        = 3'd0,
        RES_HEADER    = 3'd1,
        RES_STARBOARD = 3'd2,
        RES_STATUS1   = 3'd3,
        RES_PORT      = 3'd4,
        RES_STATUS2   = 3'd5,
        RES_SOURCE    = 3'd6
    } res_code_t;

    typedef struct packed {
        res_code_t   code;
        logic [16:0] starboard_angle;
        logic        starboard_status;
        logic [16:0] port_angle;
        logic        port_status;
        logic [63:0] source_text;
        logic [3:0]  source_length;
    } result_t;

endpackage

[hdl/nrop_core.sv]
// Input word register, per-sentence state and the combinational byte update.
module nrop_core
    import nrop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        sentence_end,
    input  logic        res_free,
    output logic        res_valid,
    output result_t     res
);

    typedef struct packed {
        logic [2:0]  field;
        logic [3:0]  cif;
        logic        hdr;
        logic [16:0] acc;
        logic [1:0]  dots;
        logic [1:0]  frac;
        logic        seen;
        logic [16:0] sv;
        logic [16:0] pv;
        logic [1:0]  stat;
        logic [63:0] src;
        logic [3:0]  cnt;
        res_code_t   err;
    } sent_t;

    localparam sent_t SENT_CLEAR = '{
        field: 3'd0, cif: 4'd0, hdr: 1'b1, acc: 17'd0, dots: 2'd0, frac: 2'd0,
        seen: 1'b0, sv: 17'd0, pv: 17'd0, stat: 2'd0, src: 64'd0, cnt: 4'd0,
        err: RES_OK
    };

    function automatic sent_t fail(input sent_t s, input res_code_t code);
        sent_t r;
        r = s;
        if (r.err == RES_OK)
            r.err = code;
        return r;
    endfunction

    function automatic logic [16:0] sat(input logic [20:0] v);
        return (v > 21'(ANGLE_MAX)) ? ANGLE_MAX : v[16:0];
    endfunction

    function automatic sent_t close_field(input sent_t s);
        sent_t r;
        r = s;
        case (s.field)
            3'd0: if (!(s.hdr && s.cif == 4'd6)) r = fail(r, RES_HEADER);
            3'd1: begin
                if (!s.seen) r = fail(r, RES_STARBOARD);
                r.sv = s.acc;
            end
            3'd3: begin
                if (!s.seen) r = fail(r, RES_PORT);
                r.pv = s.acc;
            end
            3'd2: if (s.cif != 4'd1) r = fail(r, RES_STATUS1);
            3'd4: if (s.cif != 4'd1) r = fail(r, RES_STATUS2);
            3'd5: if (s.cif == 4'd0) r = fail(r, RES_SOURCE);
            default: r = s;
        endcase
        return r;
    endfunction

    function automatic sent_t take_byte(input sent_t s, input logic [7:0] c);
        sent_t       r;
        logic        is_digit;
        logic [3:0]  d;
        logic [20:0] acc_w;
        logic [2:0]  slot;
        r = s;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d = 4'(c - CH_ZERO);
        acc_w = 21'(s.acc);
        slot = 3'd7 - s.cnt[2:0];
        if (s.field >= 3'd6) begin
            r = s;
        end else if (s.field < 3'd5 && c == CH_COMMA) begin
            r = close_field(s);
            r.field = s.field + 3'd1;
            r.cif = 4'd0;
            r.acc = 17'd0;
            r.dots = 2'd0;
            r.frac = 2'd0;
            r.seen = 1'b0;
        end else if (s.field == 3'd5 && c == CH_STAR) begin
            r = close_field(s);
            r.field = 3'd6;
        end else begin
            case (s.field)
                3'd0: begin
                    if (s.cif >= 4'd3 && s.cif <= 4'd5 && c != HDR_TAG[2'(s.cif - 4'd3)])
                        r.hdr = 1'b0;
                end
                3'd1, 3'd3: begin
                    if (is_digit) begin
                        if (s.dots == 2'd0) begin
                            // Integer digit: shift up one decade, the digit weighs 100.
                            r.acc = sat((acc_w << 3) + (acc_w << 1) + 21'(d) * 21'd100);
                            r.seen = 1'b1;
                        end else if (s.dots == 2'd1) begin
                            if (s.frac < 2'd2) begin
                                r.acc = sat(acc_w + ((s.frac == 2'd0) ?
                                        21'(d) * 21'd10 : 21'(d)));
                                r.frac = s.frac + 2'd1;
                            end
                            r.seen = 1'b1;
                        end
                    end else if (c == CH_DOT) begin
                        if (s.dots < 2'd2)
                            r.dots = s.dots + 2'd1;
                    end else begin
                        r = fail(r, (s.field == 3'd1) ? RES_STARBOARD : RES_PORT);
                    end
                end
                3'd2, 3'd4: begin
                    if (s.cif == 4'd0 && (c == CH_A || c == CH_V)) begin
                        if (s.field == 3'd2)
                            r.stat[0] = (c == CH_A);
                        else
                            r.stat[1] = (c == CH_A);
                    end else begin
                        r = fail(r, (s.field == 3'd2) ? RES_STATUS1 : RES_STATUS2);
                    end
                end
                default: begin
                    if (!(is_digit || c == CH_DOT))
                        r = fail(r, RES_SOURCE);
                    if (32'(s.cnt) < SOURCE_CHARS)
                        r.src[8*slot +: 8] = c;
                    if (s.cnt < 4'd15)
                        r.cnt = s.cnt + 4'd1;
                end
            endcase
            if (s.cif < 4'd15)
                r.cif = s.cif + 4'd1;
        end
        return r;
    endfunction

    logic        ibuf_valid_reg;
    logic [7:0]  ibuf_char_reg;
    logic        ibuf_end_reg;
    sent_t       sent_reg;
    sent_t       sent_next;
    sent_t       after;
    sent_t       fin;
    logic        step;

    assign step     = ibuf_valid_reg && (!ibuf_end_reg || res_free);
    assign in_stall = ibuf_valid_reg && !step;

    always_comb
    begin
        after = take_byte(sent_reg, ibuf_char_reg);
        fin = after;
        // A sentence cut short closes its open field, then fails on the first field that never began.
        if (after.field <= 3'd5) begin
            fin = close_field(after);
            if (after.field < 3'd5)
                fin = fail(fin, res_code_t'(after.field + 3'd2));
        end
        sent_next = ibuf_end_reg ? SENT_CLEAR : after;
    end

    always_comb
    begin
        res_valid = step && ibuf_end_reg;
        res = '0;
        res.code = fin.err;
        if (fin.err == RES_OK) begin
            res.starboard_angle  = fin.sv;
            res.starboard_status = fin.stat[0];
            res.port_angle       = fin.pv;
            res.port_status      = fin.stat[1];
            res.source_text      = fin.src;
            res.source_length    = fin.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ibuf_valid_reg <= 1'b0;
            sent_reg       <= SENT_CLEAR;
        end else begin
            if (in_valid && !in_stall)
                ibuf_valid_reg <= 1'b1;
            else if (step)
                ibuf_valid_reg <= 1'b0;
            if (step)
                sent_reg <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            ibuf_char_reg <= char_code;
            ibuf_end_reg  <= sentence_end;
        end
    end

endmodule

[hdl/nrop_out.sv]
// Result register that holds a finished word until the downstream side takes it.
module nrop_out
    import nrop_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    output logic    res_free,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_res
);

    logic    out_valid_reg;
    result_t out_res_reg;

    assign res_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (res_free) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res_valid)
            out_res_reg <= res;
    end

endmodule

[hdl/nmea_rudder_order_parser.sv]
// Top level of the rudder-order sentence parser.
// Takes one byte word per cycle while in_stall is low and gives one result word
// per sentence, on the cycle after its last byte has moved from the input
// register through the byte update. Each byte passes an input register, the
// field logic and, on the last byte, a result register, so the sustained rate
// is one byte per cycle while the result side is free; a stalled result holds
// the final byte of the next sentence in the input register, while all earlier
// bytes keep flowing.
module nmea_rudder_order_parser
    import nrop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        sentence_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_code,
    output logic [16:0] starboard_angle,
    output logic        starboard_status,
    output logic [16:0] port_angle,
    output logic        port_status,
    output logic [63:0] source_text,
    output logic [3:0]  source_length
);

    logic    res_free;
    logic    res_valid;
    result_t res;
    result_t out_res;

    nrop_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .sentence_end (sentence_end),
        .res_free     (res_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    nrop_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign result_code      = out_res.code;
    assign starboard_angle  = out_res.starboard_angle;
    assign starboard_status = out_res.starboard_status;
    assign port_angle       = out_res.port_angle;
    assign port_status      = out_res.port_status;
    assign source_text      = out_res.source_text;
    assign source_length    = out_res.source_length;

endmodule

[verif/nmea_rudder_order_parser_tb.sv]
// Testbench for the rudder-order sentence parser: directed sentences, then random traffic under idling and stalling.
module nmea_rudder_order_parser_tb;
    import nrop_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    localparam logic [2:0] FIELD_HEADER    = 3'd0;
    localparam logic [2:0] FIELD_STARBOARD = 3'd1;
    localparam logic [2:0] FIELD_STATUS1   = 3'd2;
    localparam logic [2:0] FIELD_PORT      = 3'd3;
    localparam logic [2:0] FIELD_STATUS2   = 3'd4;
    localparam logic [2:0] FIELD_SOURCE    = 3'd5;
    localparam logic [2:0] FIELD_DONE      = 3'd6;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_code;
    logic        sentence_end;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  result_code;
    logic [16:0] starboard_angle;
    logic        starboard_status;
    logic [16:0] port_angle;
    logic        port_status;
    logic [63:0] source_text;
    logic [3:0]  source_length;

    int idle_percent  = 0;
    int stall_percent = 0;
    int cycle_count   = 0;
    int mismatch_count = 0;
    int bytes_sent     = 0;
    int sentences_sent = 0;
    int orders_checked = 0;

    // Parser state as the block should hold it.
    logic [2:0]  parse_field;
    logic [3:0]  field_chars;
    logic        header_ok;
    logic [16:0] angle_acc;
    logic [1:0]  dot_count;
    logic [1:0]  frac_count;
    logic        digit_seen;
    logic [16:0] starboard_hold;
    logic [16:0] port_hold;
    logic [1:0]  status_hold;
    logic [63:0] source_hold;
    logic [3:0]  source_len;
    res_code_t   first_error;

    result_t    expected_orders[$];
    logic [7:0] sentence_bytes[$];

    nmea_rudder_order_parser DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_code        (char_code),
        .sentence_end     (sentence_end),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_code      (result_code),
        .starboard_angle  (starboard_angle),
        .starboard_status (starboard_status),
        .port_angle       (port_angle),
        .port_status      (port_status),
        .source_text      (source_text),
        .source_length    (source_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------- parser prediction

    function void clear_sentence();
        parse_field    = FIELD_HEADER;
        field_chars    = '0;
        header_ok      = 1'b1;
        angle_acc      = '0;
        dot_count      = '0;
        frac_count     = '0;
        digit_seen     = 1'b0;
        starboard_hold = '0;
        port_hold      = '0;
        status_hold    = '0;
        source_hold    = '0;
        source_len     = '0;
        first_error    = RES_OK;
    endfunction

    function res_code_t field_error_code(logic [2:0] fld);
        case (fld)
            FIELD_HEADER:    return RES_HEADER;
            FIELD_STARBOARD: return RES_STARBOARD;
            FIELD_STATUS1:   return RES_STATUS1;
            FIELD_PORT:      return RES_PORT;
            FIELD_STATUS2:   return RES_STATUS2;
            default:         return RES_SOURCE;
        endcase
    endfunction

    // Only the first failing field is reported.
    function void flag_error(res_code_t code);
        if (first_error == RES_OK)
            first_error = code;
    endfunction

    function void angle_char(logic [7:0] c, res_code_t code);
        int sum;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (dot_count == 0)
            begin
                sum = angle_acc * 10 + (c - CH_ZERO) * 100;
                angle_acc = (sum > ANGLE_MAX) ? ANGLE_MAX : sum[16:0];
                digit_seen = 1'b1;
            end
            else if (dot_count == 1)
            begin
                // Only two fraction digits count; the rest are dropped.
                if (frac_count < 2)
                begin
                    sum = angle_acc + (c - CH_ZERO) * ((frac_count == 0) ? 10 : 1);
                    angle_acc = (sum > ANGLE_MAX) ? ANGLE_MAX : sum[16:0];
                    frac_count++;
                end
                digit_seen = 1'b1;
            end
        end
        else if (c == CH_DOT)
        begin
            if (dot_count < 2)
                dot_count++;
        end
        else
        begin
            flag_error(code);
        end
    endfunction

    function void close_field();
        case (parse_field)
            FIELD_HEADER:
                if (!(header_ok && field_chars == 6))
                    flag_error(RES_HEADER);
            FIELD_STARBOARD, FIELD_PORT:
            begin
                if (!digit_seen)
                    flag_error(field_error_code(parse_field));
                if (parse_field == FIELD_STARBOARD)
                    starboard_hold = angle_acc;
                else
                    port_hold = angle_acc;
            end
            FIELD_STATUS1, FIELD_STATUS2:
                if (field_chars != 1)
                    flag_error(field_error_code(parse_field));
            FIELD_SOURCE:
                if (field_chars == 0)
                    flag_error(RES_SOURCE);
            default:
                ;
        endcase
    endfunction

    function void take_byte(logic [7:0] c);
        if (parse_field >= FIELD_DONE)
            return;
        if (parse_field < FIELD_SOURCE && c == CH_COMMA)
        begin
            close_field();
            parse_field = parse_field + 3'd1;
            field_chars = '0;
            angle_acc   = '0;
            dot_count   = '0;
            frac_count  = '0;
            digit_seen  = 1'b0;
            return;
        end
        if (parse_field == FIELD_SOURCE && c == CH_STAR)
        begin
            close_field();
            parse_field = FIELD_DONE;
            return;
        end
        case (parse_field)
            FIELD_HEADER:
                if (field_chars >= 3 && field_chars <= 5 &&
                    c != HDR_TAG[2'(field_chars - 4'd3)])
                    header_ok = 1'b0;
            FIELD_STARBOARD, FIELD_PORT:
                angle_char(c, field_error_code(parse_field));
            FIELD_STATUS1, FIELD_STATUS2:
                if (field_chars == 0 && (c == CH_A || c == CH_V))
                    status_hold[parse_field == FIELD_STATUS2] = (c == CH_A);
                else
                    flag_error(field_error_code(parse_field));
            default:
            begin
                if (!((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT))
                    flag_error(RES_SOURCE);
                if (source_len < SOURCE_CHARS)
                    source_hold[8 * (7 - int'(source_len)) +: 8] = c;
                if (source_len < 15)
                    source_len++;
            end
        endcase
        if (field_chars < 15)
            field_chars++;
    endfunction

    function void predict_byte(logic [7:0] c, logic last);
        result_t order;
        take_byte(c);
        if (!last)
            return;
        if (parse_field <= FIELD_SOURCE)
        begin
            close_field();
            // Fields that never began count as empty; the next one fails first.
            if (parse_field < FIELD_SOURCE)
                flag_error(field_error_code(parse_field + 3'd1));
        end
        order = '0;
        order.code = first_error;
        if (first_error == RES_OK)
        begin
            order.starboard_angle  = starboard_hold;
            order.starboard_status = status_hold[0];
            order.port_angle       = port_hold;
            order.port_status      = status_hold[1];
            order.source_text      = source_hold;
            order.source_length    = source_len;
        end
        expected_orders.push_back(order);
        clear_sentence();
    endfunction

    // ---------------------------------------------------------------- result checking

    function void compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    initial
    begin : order_checker
        result_t want;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                orders_checked++;
                if (expected_orders.size() == 0)
                begin
                    $error("result word with none expected, result_code %0d", result_code);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_orders.pop_front();
                    compare_field("result_code", 64'(want.code), 64'(result_code));
                    compare_field("starboard_angle", 64'(want.starboard_angle),
                                  64'(starboard_angle));
                    compare_field("starboard_status", 64'(want.starboard_status),
                                  64'(starboard_status));
                    compare_field("port_angle", 64'(want.port_angle), 64'(port_angle));
                    compare_field("port_status", 64'(want.port_status), 64'(port_status));
                    compare_field("source_text", want.source_text, source_text);
                    compare_field("source_length", 64'(want.source_length),
                                  64'(source_length));
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_percent);
        end
    end

    // ---------------------------------------------------------------- sending

    task send_byte(logic [7:0] c, logic last);
        while ($urandom_range(0, 99) < idle_percent)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        char_code    <= c;
        sentence_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(c, last);
        bytes_sent++;
    endtask

    task send_sentence();
        for (int i = 0; i < sentence_bytes.size(); i++)
            send_byte(sentence_bytes[i], i == sentence_bytes.size() - 1);
        sentences_sent++;
    endtask

    function void put_byte(logic [7:0] b);
        sentence_bytes.push_back(b);
    endfunction

    function void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endfunction

    task send_text(string s);
        sentence_bytes.delete();
        put_text(s);
        send_sentence();
    endtask

    // Holds the input idle until every outstanding result word has been taken.
    task drain_orders();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_orders.size() != 0);
    endtask

    // ---------------------------------------------------------------- random sentences

    function void put_digits(int n);
        repeat (n)
            put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function void put_angle();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return;
        if (pick == 1)
        begin
            put_byte(CH_DOT);
            put_digits($urandom_range(0, 2));
            return;
        end
        if (pick == 2)
        begin
            put_digits($urandom_range(4, 7));
            return;
        end
        put_digits($urandom_range(1, 3));
        if ($urandom_range(0, 2) != 0)
        begin
            put_byte(CH_DOT);
            put_digits($urandom_range(0, 4));
            if ($urandom_range(0, 7) == 0)
            begin
                put_byte(CH_DOT);
                put_digits($urandom_range(0, 2));
            end
        end
    endfunction

    function void put_status();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return;
        if (pick == 1)
            put_text("AV");
        else if (pick == 2)
            put_byte(8'(CH_A + $urandom_range(0, 25)));
        else
            put_byte($urandom_range(0, 1) ? CH_A : CH_V);
    endfunction

    function void put_source();
        int count;
        string hex_digits;
        hex_digits = "0123456789ABCDEF";
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : $urandom_range(1, 9);
        repeat (count)
            put_byte(8'(($urandom_range(0, 5) == 0) ? CH_DOT : CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0)
            return;
        put_byte(CH_STAR);
        put_byte(hex_digits[$urandom_range(0, 15)]);
        put_byte(hex_digits[$urandom_range(0, 15)]);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                put_byte(8'($urandom_range(0, 255)));
    endfunction

    function void build_random_sentence();
        int kind;
        int cut;
        sentence_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 12))
                put_byte(8'(($urandom_range(0, 3) == 0) ? CH_COMMA : $urandom_range(0, 255)));
            return;
        end
        put_text("$");
        put_byte(8'(CH_A + $urandom_range(0, 25)));
        put_byte(8'(CH_A + $urandom_range(0, 25)));
        put_text("ROR,");
        put_angle();
        put_text(",");
        put_status();
        put_text(",");
        put_angle();
        put_text(",");
        put_status();
        put_text(",");
        put_source();
        cut = $urandom_range(0, sentence_bytes.size() - 1);
        if (kind == 1)
            sentence_bytes[cut] = 8'($urandom_range(0, 255));
        else if (kind == 2)
            while (sentence_bytes.size() > cut + 1)
                void'(sentence_bytes.pop_back());
    endfunction

    // ---------------------------------------------------------------- tests

    task test_well_formed();
        send_text("$AGROR,12.5,A,3.75,V,01*5C");
        send_text("$IIROR,0,V,0.0,A,.*00");
        send_text("$xxROR,999.99,A,1000,A,0123456789.12345678*7F");
        send_text("$AGROR,5.,V,.25,V,7*");
    endtask

    task test_header_rules();
        send_text("$AGRSA,1,A,1,A,1*00");
        send_text("$GROR,1,A,1,A,1");
        send_text("$AGXROR,1,A,1,A,1*");
    endtask

    task test_angle_rules();
        send_text("$AGROR,12.345,A,1.2.39,V,5");
        send_text("$AGROR,123456,A,..5,V,5");
        send_text("$AGROR,,A,1,A,5");
        send_text("$AGROR,1x,A,1,A,5");
        sentence_bytes.delete();
        put_text("$AGROR,");
        put_byte(8'h00);
        put_text(",A,1,A,5");
        send_sentence();
    endtask

    task test_status_rules();
        send_text("$AGROR,1,,1,A,5");
        send_text("$AGROR,1,AV,1,A,5");
        send_text("$AGROR,1,A,1,X,5");
        // Several bad fields: the starboard angle is the first to fail.
        send_text("$AGROR,x,Q,y,Z,?");
    endtask

    task test_source_rules();
        send_text("$AGROR,1,A,1,A,12,34*");
        send_text("$AGROR,1,A,1,A,*12");
        send_text("$AGROR,1,A,1,A,4.5*,,xyz");
        sentence_bytes.delete();
        put_text("$AGROR,1,A,1,A,9*");
        put_byte(8'hFF);
        put_byte(8'h00);
        send_sentence();
    endtask

    task test_cut_short();
        send_text("$AGROR,1");
        send_text("$AGROR");
        send_text("$AGROR,1,A,1,A");
        send_text("$AGROR,1,A,1,A,77");
        send_text("*");
    endtask

    task test_random_traffic(int idle, int stall, int count);
        idle_percent  = idle;
        stall_percent = stall;
        repeat (count)
        begin
            build_random_sentence();
            send_sentence();
            // Now and then let the output run dry before carrying on.
            if ($urandom_range(0, 15) == 0)
                drain_orders();
        end
        drain_orders();
    endtask

    initial
    begin : stimulus
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        char_code    <= '0;
        sentence_end <= 1'b0;
        clear_sentence();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_well_formed();
        test_header_rules();
        drain_orders();
        test_angle_rules();
        test_status_rules();
        test_source_rules();
        test_cut_short();
        drain_orders();

        test_random_traffic(0, 0, 2);
        test_random_traffic(68, 0, 2);
        test_random_traffic(0, 68, 2);
        test_random_traffic(32, 32, 2);

        repeat (8) @(posedge clk);
        $display("Sent %0d sentences (%0d byte words) and compared %0d result words.",
                 sentences_sent, bytes_sent, orders_checked);
        $display("Traffic ran with no idling, an idle sender, a stalling receiver and both.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
hdl/nrop_pkg.sv
hdl/nrop_core.sv
hdl/nrop_out.sv
hdl/nmea_rudder_order_parser.sv
verif/nmea_rudder_order_parser_tb.sv
